[sv/peak_detect_threshold_distance_defines.svh]
// ----------------------------------------------------------------------------
// peak detector assertion macros
// concurrent assertion helpers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef PEAK_DETECT_THRESHOLD_DISTANCE_DEFINES_SVH
`define PEAK_DETECT_THRESHOLD_DISTANCE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PDTD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("peak detector assertion failed");
// next-cycle implication
`define PDTD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("peak detector assertion failed");
`else
`define PDTD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PDTD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[sv/pdtd_pkg.sv]
// ----------------------------------------------------------------------------
// pdtd_pkg
// shared types and constants of the peak detector
// ----------------------------------------------------------------------------
package pdtd_pkg;

  localparam int MAX_FRAME_LEN_DEF = 65536;
  localparam int SAMPLE_BITS_DEF   = 16;

  localparam int THRESH_W  = 16;
  localparam int DIST_W    = 16;
  localparam int INDEX_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PEAK_DISTANCE = 2'd1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic signed [THRESH_W-1:0] peak_threshold;
    logic [DIST_W-1:0]          min_peak_distance;
  } cfg_t;

  typedef struct packed {
    logic [INDEX_W-1:0] peak_index;
    logic               peak_found;
    logic               frame_end;
  } result_t;

  typedef struct packed {
    logic                  full;
    logic                  not_empty;
    logic [FIFO_CNT_W-1:0] count;
  } fifo_stat_t;

endpackage

[sv/pdtd_front.sv]
// ----------------------------------------------------------------------------
// pdtd_front
// sample window and peak decision, one item per cycle while accept is high
// ----------------------------------------------------------------------------
module pdtd_front #(
  parameter int MAX_FRAME_LEN = pdtd_pkg::MAX_FRAME_LEN_DEF,
  parameter int SAMPLE_BITS   = pdtd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  logic [SAMPLE_BITS-1:0]  sample,
  input  logic                    frame_last,
  input  pdtd_pkg::cfg_t          cfg,
  output logic                    res_valid,
  output pdtd_pkg::result_t       res
);
  import pdtd_pkg::*;

  localparam int CNT_W  = $clog2(MAX_FRAME_LEN + 1);
  localparam int IDX_W  = $clog2(MAX_FRAME_LEN);
  localparam int CMP_W  = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
  localparam int DCMP_W = (IDX_W > DIST_W) ? IDX_W : DIST_W;

  logic signed [SAMPLE_BITS-1:0] older_r, older_nxt;
  logic signed [SAMPLE_BITS-1:0] middle_r, middle_nxt;
  logic [CNT_W-1:0]              seen_r, seen_nxt;
  logic [IDX_W-1:0]              last_pos_r, last_pos_nxt;
  logic                          recorded_r, recorded_nxt;

  logic signed [SAMPLE_BITS-1:0] cur;
  logic signed [CMP_W-1:0]       mid_x, old_x, cur_x, thr_x;
  logic                          active, have_two;
  logic [IDX_W-1:0]              cand, gap;
  logic                          height_ok, local_max, far_ok, found;

  assign cur    = signed'(sample);
  assign mid_x  = middle_r;
  assign old_x  = older_r;
  assign cur_x  = cur;
  assign thr_x  = cfg.peak_threshold;

  assign active   = seen_r < CNT_W'(MAX_FRAME_LEN);
  assign have_two = seen_r >= CNT_W'(2);
  assign cand     = IDX_W'(seen_r - CNT_W'(1));
  assign gap      = cand - last_pos_r;

  assign height_ok = !(!cfg.peak_threshold[THRESH_W-1] && (mid_x < thr_x));
  assign local_max = (mid_x > old_x) && (mid_x > cur_x);
  assign far_ok    = !recorded_r ||
                     (DCMP_W'(gap) >= DCMP_W'(cfg.min_peak_distance));
  assign found     = active && have_two && height_ok && local_max && far_ok;

  assign res_valid      = accept && (found || frame_last);
  assign res.peak_index = found ? INDEX_W'(cand) : '0;
  assign res.peak_found = found;
  assign res.frame_end  = frame_last;

  always_comb begin
    older_nxt    = older_r;
    middle_nxt   = middle_r;
    seen_nxt     = seen_r;
    last_pos_nxt = last_pos_r;
    recorded_nxt = recorded_r;
    if (accept) begin
      if (found) begin
        last_pos_nxt = cand;
        recorded_nxt = 1'b1;
      end
      // past the frame-length bound the window freezes
      if (active) begin
        older_nxt  = middle_r;
        middle_nxt = cur;
        seen_nxt   = seen_r + CNT_W'(1);
      end
      if (frame_last) begin
        older_nxt    = '0;
        middle_nxt   = '0;
        seen_nxt     = '0;
        last_pos_nxt = '0;
        recorded_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r    <= '0;
      middle_r   <= '0;
      seen_r     <= '0;
      last_pos_r <= '0;
      recorded_r <= 1'b0;
    end else begin
      older_r    <= older_nxt;
      middle_r   <= middle_nxt;
      seen_r     <= seen_nxt;
      last_pos_r <= last_pos_nxt;
      recorded_r <= recorded_nxt;
    end
  end

endmodule

[sv/pdtd_fifo.sv]
// ----------------------------------------------------------------------------
// pdtd_fifo
// short result queue between decision front and output stage
// ----------------------------------------------------------------------------
module pdtd_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr_en,
  input  pdtd_pkg::result_t      wr_data,
  input  logic                   rd_en,
  output pdtd_pkg::result_t      rd_data,
  output pdtd_pkg::fifo_stat_t   stat
);
  import pdtd_pkg::*;

  result_t               slot_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  do_wr, do_rd;

  assign stat.full      = cnt_r == FIFO_CNT_W'(FIFO_DEPTH);
  assign stat.not_empty = cnt_r != '0;
  assign stat.count     = cnt_r;

  assign do_wr   = wr_en && !stat.full;
  assign do_rd   = rd_en && stat.not_empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + FIFO_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + FIFO_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + FIFO_CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[sv/pdtd_back.sv]
// ----------------------------------------------------------------------------
// pdtd_back
// output register that drains the result queue
// ----------------------------------------------------------------------------
module pdtd_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_avail,
  input  pdtd_pkg::result_t               q_data,
  output logic                            q_rd,
  input  logic                            out_pop,
  output logic                            out_empty,
  output logic [pdtd_pkg::INDEX_W-1:0]    out_peak_index,
  output logic                            out_peak_found,
  output logic                            out_frame_end
);
  import pdtd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;
  logic    take;

  // refill when the held item leaves or nothing is held
  assign take = q_avail && (!valid_r || out_pop);
  assign q_rd = take;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign out_empty      = !valid_r;
  assign out_peak_index = data_r.peak_index;
  assign out_peak_found = data_r.peak_found;
  assign out_frame_end  = data_r.frame_end;

endmodule

[sv/peak_detect_threshold_distance.sv]
// ----------------------------------------------------------------------------
// peak_detect_threshold_distance
// streaming local-maximum peak detector with height and distance limits
// ----------------------------------------------------------------------------
// Takes one signed sample per cycle, back to back unless in_full is high, and
// reports a peak one item later, when the following sample arrives; the
// first and last samples of a frame never count. A sample is a peak when
// strictly above both neighbours, at least peak_threshold (unless the
// threshold is negative) and at least min_peak_distance indices after the
// previous peak of the frame. The item flagged frame_last always yields a
// result with frame_end set, and the frame state is then cleared. The front
// stage decides combinationally; a four-entry queue and an output register
// follow, and a result passes both before it is poppable. Input only stalls
// when that queue is full. Configuration is taken at any time (cfg_ready is
// always high) but should be written between frames.
module peak_detect_threshold_distance #(
  parameter int MAX_FRAME_LEN = pdtd_pkg::MAX_FRAME_LEN_DEF,
  parameter int SAMPLE_BITS   = pdtd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [SAMPLE_BITS-1:0]           in_sample,
  input  logic                             in_frame_last,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [pdtd_pkg::INDEX_W-1:0]     out_peak_index,
  output logic                             out_peak_found,
  output logic                             out_frame_end,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pdtd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pdtd_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import pdtd_pkg::*;

`include "peak_detect_threshold_distance_defines.svh"

  cfg_t       cfg_r, cfg_nxt;
  logic       accept;
  logic       res_valid;
  result_t    res;
  result_t    q_data;
  logic       q_rd;
  fifo_stat_t q_stat;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PEAK_THRESHOLD:    cfg_nxt.peak_threshold    = signed'(cfg_data);
        CFG_MIN_PEAK_DISTANCE: cfg_nxt.min_peak_distance = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.peak_threshold    <= -16'sd1;
      cfg_r.min_peak_distance <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_full = q_stat.full;
  assign accept  = in_push && !in_full;

  pdtd_front #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .sample     (in_sample),
    .frame_last (in_frame_last),
    .cfg        (cfg_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  pdtd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_valid),
    .wr_data (res),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .stat    (q_stat)
  );

  pdtd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_avail        (q_stat.not_empty),
    .q_data         (q_data),
    .q_rd           (q_rd),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_peak_index (out_peak_index),
    .out_peak_found (out_peak_found),
    .out_frame_end  (out_frame_end)
  );

  // every delivered item has a reason to exist
  `PDTD_ASSERT_IMP(a_result_has_cause, clk, rst_n, !out_empty && !out_peak_found, out_frame_end)
  // a frame end item is never dropped on its way to the queue
  `PDTD_ASSERT_NXT(a_frame_end_queued, clk, rst_n, accept && in_frame_last, q_stat.count != '0)
  // a result with no peak carries a zero index
  `PDTD_ASSERT_IMP(a_idle_index_zero, clk, rst_n, !out_empty && !out_peak_found, out_peak_index == '0)

endmodule
